// ===== hw/rtl/assert_macros.svh =====
// assertion helper macros for the point set normalizer checker
// used by csp_checker.sv, no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, held off during reset
`define CSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csp assertion failed");

// next-cycle implication, checked during reset as well
`define CSP_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("csp assertion failed");

`endif

// ===== hw/rtl/csp_pkg.sv =====
// shared types and constants for center_and_scale_point_set
// no dependencies
package csp_pkg;

    localparam int COORD_BITS  = 24;
    localparam int POINT_DEPTH = 64;
    localparam int ADDR_BITS   = 6;
    localparam int CNT_BITS    = 7;
    localparam int TGT_BITS    = 23;
    localparam int RAD_BITS    = 50;
    localparam int REM_BITS    = 28;
    localparam int DIVR_BITS   = 27;
    localparam int DIAG_BITS   = 26;
    localparam int MAG_BITS    = 26;
    localparam int STEP_BITS   = 6;
    localparam int ROOT_STEPS  = 25;
    localparam int DIV_STEPS   = 50;
    localparam logic [TGT_BITS-1:0] TARGET_RESET = 23'd25600;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_SQUARE,
        S_ROOT_GO,
        S_ROOT,
        S_READ,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic                 root;
        logic [RAD_BITS-1:0]  rad;
        logic [DIVR_BITS-1:0] divisor;
    } t_unit_req;

    typedef struct packed {
        logic                done;
        logic [RAD_BITS-1:0] quo;
        logic [REM_BITS-1:0] rem;
    } t_unit_rsp;

endpackage

// ===== hw/rtl/csp_root_div.sv =====
// shared bit-serial unit: integer square root (2 bits a step) or division (1 bit a step)
// depends on csp_pkg
module csp_root_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csp_pkg::t_unit_req i_req,
    output csp_pkg::t_unit_rsp o_rsp
);

    logic                                r_busy;
    logic                                r_root;
    logic                                r_done;
    logic [csp_pkg::STEP_BITS-1:0]       r_cnt;
    logic [csp_pkg::RAD_BITS-1:0]        r_rad;
    logic [csp_pkg::RAD_BITS-1:0]        r_quo;
    logic [csp_pkg::REM_BITS-1:0]        r_rem;
    logic [csp_pkg::DIVR_BITS-1:0]       r_divisor;
    logic [csp_pkg::REM_BITS-1:0]        rem_sh;
    logic [csp_pkg::REM_BITS-1:0]        trial;
    logic                                ge;

    always_comb begin
        if (r_root) begin
            rem_sh = {r_rem[csp_pkg::REM_BITS-3:0], r_rad[csp_pkg::RAD_BITS-1 -: 2]};
            trial  = {1'b0, r_quo[24:0], 2'b01};
        end else begin
            rem_sh = {r_rem[csp_pkg::REM_BITS-2:0], r_rad[csp_pkg::RAD_BITS-1]};
            trial  = {1'b0, r_divisor};
        end
        ge = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.root ? csp_pkg::STEP_BITS'(csp_pkg::ROOT_STEPS)
                                     : csp_pkg::STEP_BITS'(csp_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == csp_pkg::STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_root    <= i_req.root;
            r_rad     <= i_req.rad;
            r_divisor <= i_req.divisor;
            r_quo     <= '0;
            r_rem     <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sh - trial : rem_sh;
            r_quo <= {r_quo[csp_pkg::RAD_BITS-2:0], ge};
            r_rad <= r_root ? {r_rad[csp_pkg::RAD_BITS-3:0], 2'b00}
                            : {r_rad[csp_pkg::RAD_BITS-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== hw/rtl/center_and_scale_point_set.sv =====
// top level of the point set center and scale normalizer
// depends on csp_pkg and csp_root_div
//
// Input stream: one point per transaction, tdata = {z, y, x} (24-bit signed each),
// tlast marks the last point of a set. Points load at one per cycle into a 64-entry
// store while the bounding box is tracked. After the last point the block drops
// tready and runs a check, squares and sums the box extents and takes a 25-step
// square root in the shared unit, then per stored point reads the point and, for
// each axis, does one multiply, starts the shared unit and runs a 50-step division.
// Output stream: tdata = {z, y, x} scaled, tuser = status, tlast = end of run.
// A bad set (overflow, fewer than three points, zero box) gives one result with
// status set and zero coordinates, offered right after the check cycle.
// If the receiver stalls, the result is held and no work proceeds until it is taken;
// tready returns the cycle after the end-of-run transaction is taken.
// Synchronous active-low reset clears the set and the target to 25600; the
// target may be written any cycle through i_cfg_we while the block is idle.
module center_and_scale_point_set (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [22:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // pos_x, pos_y, pos_z
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // out_x, out_y, out_z
    output logic [1:0]  o_m_tuser,   // status
    output logic        o_m_tlast
);

    localparam int CB = csp_pkg::COORD_BITS;

    csp_pkg::t_state r_state, n_state;

    logic [CB-1:0]                    r_min [3];
    logic [CB-1:0]                    r_max [3];
    logic [CB-1:0]                    in_c  [3];
    logic [3*CB-1:0]                  r_mem [csp_pkg::POINT_DEPTH];
    logic [3*CB-1:0]                  r_rd;
    logic [csp_pkg::CNT_BITS-1:0]     r_count;
    logic [csp_pkg::CNT_BITS-1:0]     r_idx;
    logic                             r_ovf;
    logic [csp_pkg::TGT_BITS-1:0]     r_target;
    logic [1:0]                       r_axis;
    logic [2:0]                       r_sq;
    logic [2*CB+1:0]                  r_acc;
    logic [csp_pkg::RAD_BITS-1:0]     r_prod;
    logic [csp_pkg::DIAG_BITS-1:0]    r_diag;
    logic                             r_neg;
    logic [CB-1:0]                    r_out [3];
    logic [1:0]                       r_status;
    logic                             r_last;

    logic                             s_acc;
    logic                             first;
    logic [CB-1:0]                    d     [3];
    logic                             box_zero;
    logic [CB-1:0]                    p_sel, lo_sel, hi_sel;
    logic [csp_pkg::MAG_BITS-1:0]     num;
    logic [csp_pkg::MAG_BITS-1:0]     mag;
    logic [csp_pkg::MAG_BITS-1:0]     mul_a;
    logic [CB-1:0]                    mul_b;
    logic [csp_pkg::RAD_BITS-1:0]     prod;
    logic [CB-1:0]                    sat;
    logic [24:0]                      root;
    csp_pkg::t_unit_req               req;
    csp_pkg::t_unit_rsp               rsp;

    csp_root_div u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    assign o_s_tready = (r_state == csp_pkg::S_LOAD);
    assign o_m_tvalid = (r_state == csp_pkg::S_OUT);
    assign o_m_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign first      = (r_count == '0) && !r_ovf;
    assign in_c[0]    = i_s_tdata[CB-1:0];
    assign in_c[1]    = i_s_tdata[2*CB-1:CB];
    assign in_c[2]    = i_s_tdata[3*CB-1:2*CB];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d[k] = CB'($signed({r_max[k][CB-1], r_max[k]}) - $signed({r_min[k][CB-1], r_min[k]}));
        end
        box_zero = (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
        case (r_axis)
            2'd1: begin
                p_sel = r_rd[2*CB-1:CB];
                lo_sel = r_min[1];
                hi_sel = r_max[1];
            end
            2'd2: begin
                p_sel = r_rd[3*CB-1:2*CB];
                lo_sel = r_min[2];
                hi_sel = r_max[2];
            end
            default: begin
                p_sel = r_rd[CB-1:0];
                lo_sel = r_min[0];
                hi_sel = r_max[0];
            end
        endcase
        num = csp_pkg::MAG_BITS'($signed({p_sel[CB-1], p_sel, 1'b0})
              - ($signed({{2{lo_sel[CB-1]}}, lo_sel}) + $signed({{2{hi_sel[CB-1]}}, hi_sel})));
        mag = num[csp_pkg::MAG_BITS-1] ? -num : num;
        if (r_state == csp_pkg::S_SQUARE) begin
            mul_a = {2'b00, d[r_sq[1:0] == 2'd3 ? 2'd0 : r_sq[1:0]]};
            mul_b = d[r_sq[1:0] == 2'd3 ? 2'd0 : r_sq[1:0]];
        end else begin
            mul_a = mag;
            mul_b = {1'b0, r_target};
        end
        prod = {{CB{1'b0}}, mul_a} * {{csp_pkg::MAG_BITS{1'b0}}, mul_b};
        if (r_neg) begin
            sat = (rsp.quo > csp_pkg::RAD_BITS'(1 << (CB - 1))) ? {1'b1, {(CB-1){1'b0}}}
                                                                 : -rsp.quo[CB-1:0];
        end else begin
            sat = (rsp.quo > csp_pkg::RAD_BITS'((1 << (CB - 1)) - 1)) ? {1'b0, {(CB-1){1'b1}}}
                                                                       : rsp.quo[CB-1:0];
        end
        root = rsp.quo[24:0];
        req.start   = (r_state == csp_pkg::S_ROOT_GO) || (r_state == csp_pkg::S_DIV_GO);
        req.root    = (r_state == csp_pkg::S_ROOT_GO);
        req.rad     = (r_state == csp_pkg::S_ROOT_GO) ? r_acc
                      : r_prod + csp_pkg::RAD_BITS'(r_diag);
        req.divisor = {r_diag, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csp_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            csp_pkg::S_LOAD: begin
                if (s_acc && i_s_tlast) n_state = csp_pkg::S_CHECK;
            end
            csp_pkg::S_CHECK: begin
                if (r_ovf || r_count < csp_pkg::CNT_BITS'(3) || box_zero) begin
                    n_state = csp_pkg::S_OUT;
                end else begin
                    n_state = csp_pkg::S_SQUARE;
                end
            end
            csp_pkg::S_SQUARE: begin
                if (r_sq == 3'd3) n_state = csp_pkg::S_ROOT_GO;
            end
            csp_pkg::S_ROOT_GO: n_state = csp_pkg::S_ROOT;
            csp_pkg::S_ROOT: begin
                if (rsp.done) n_state = csp_pkg::S_READ;
            end
            csp_pkg::S_READ: n_state = csp_pkg::S_MUL;
            csp_pkg::S_MUL: n_state = csp_pkg::S_DIV_GO;
            csp_pkg::S_DIV_GO: n_state = csp_pkg::S_DIV;
            csp_pkg::S_DIV: begin
                if (rsp.done) n_state = (r_axis == 2'd2) ? csp_pkg::S_OUT : csp_pkg::S_MUL;
            end
            csp_pkg::S_OUT: begin
                if (i_m_tready) n_state = r_last ? csp_pkg::S_LOAD : csp_pkg::S_READ;
            end
            default: n_state = csp_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_target <= csp_pkg::TARGET_RESET;
        end else begin
            if (i_cfg_we) r_target <= i_cfg_wdata;
            if (s_acc) begin
                if (!r_count[csp_pkg::CNT_BITS-1]) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_state == csp_pkg::S_OUT && i_m_tready && r_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            for (int k = 0; k < 3; k++) begin
                if (first || $signed(in_c[k]) < $signed(r_min[k])) r_min[k] <= in_c[k];
                if (first || $signed(in_c[k]) > $signed(r_max[k])) r_max[k] <= in_c[k];
            end
            if (!r_count[csp_pkg::CNT_BITS-1]) begin
                r_mem[r_count[csp_pkg::ADDR_BITS-1:0]] <= i_s_tdata;
            end
        end
        if (r_state == csp_pkg::S_READ) r_rd <= r_mem[r_idx[csp_pkg::ADDR_BITS-1:0]];
        case (r_state)
            csp_pkg::S_CHECK: begin
                r_sq  <= '0;
                r_acc <= '0;
                r_idx <= '0;
                r_last <= 1'b1;
                for (int k = 0; k < 3; k++) r_out[k] <= '0;
                if (r_ovf) r_status <= csp_pkg::ST_OVERFLOW;
                else if (r_count < csp_pkg::CNT_BITS'(3)) r_status <= csp_pkg::ST_FEW;
                else if (box_zero) r_status <= csp_pkg::ST_ZERO;
                else r_status <= csp_pkg::ST_OK;
            end
            csp_pkg::S_SQUARE: begin
                r_sq <= r_sq + 1'b1;
                if (r_sq != 3'd3) r_prod <= prod;
                if (r_sq != 3'd0) r_acc <= r_acc + r_prod;
            end
            csp_pkg::S_ROOT: begin
                if (rsp.done) begin
                    r_diag <= (rsp.rem > csp_pkg::REM_BITS'(root))
                              ? csp_pkg::DIAG_BITS'(root) + 1'b1 : csp_pkg::DIAG_BITS'(root);
                end
            end
            csp_pkg::S_READ: begin
                r_axis <= '0;
                r_last <= (r_idx + 1'b1 == r_count);
            end
            csp_pkg::S_MUL: begin
                r_prod <= prod;
                r_neg  <= num[csp_pkg::MAG_BITS-1];
            end
            csp_pkg::S_DIV: begin
                if (rsp.done) begin
                    r_out[r_axis] <= sat;
                    r_axis <= r_axis + 1'b1;
                end
            end
            csp_pkg::S_OUT: begin
                if (i_m_tready) r_idx <= r_idx + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/csp_checker.sv =====
// port-level checker for center_and_scale_point_set, bound to the top level
// depends on assert_macros.svh and csp_pkg
`include "assert_macros.svh"

module csp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // input side is closed while a result is offered
    `CSP_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_m_tvalid, !o_s_tready)
    // error results carry zero coordinates and close the run
    `CSP_ASSERT_IMPL(a_err_shape, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != csp_pkg::ST_OK,
        o_m_tlast && o_m_tdata == 72'd0)
    // after reset the block waits for points
    `CSP_ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, o_s_tready && !o_m_tvalid)
    // a taken end of run reopens the input
    `CSP_ASSERT_IMPL(a_reopen, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tlast,
        ##1 o_s_tready)

endmodule

bind center_and_scale_point_set csp_checker u_csp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ===== tb/tb_top.sv =====
// self-checking bench for center_and_scale_point_set: point sets in, scaled points out
// depends on csp_pkg and the block rtl; predicts each set in-bench and compares per field
module tb_top;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               last;
    } t_point;

    typedef struct {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic [1:0]  status;
        logic        last;
    } t_scaled;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [22:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    center_and_scale_point_set dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_point  pending_points[$];
    t_scaled expected_points[$];
    int      error_count = 0;
    int      points_sent = 0;
    int      results_seen = 0;
    int      sets_done = 0;
    longint  cycle_count = 0;
    bit      hold_sender = 1'b0;

    // predictor state
    logic signed [23:0] xs[csp_pkg::POINT_DEPTH];
    logic signed [23:0] ys[csp_pkg::POINT_DEPTH];
    logic signed [23:0] zs[csp_pkg::POINT_DEPTH];
    logic signed [23:0] mn_x, mn_y, mn_z, mx_x, mx_y, mx_z;
    int                 pcount = 0;
    bit                 ovf = 1'b0;
    logic [22:0]        target = csp_pkg::TARGET_RESET;

    function automatic longint unsigned isqrt_round(longint unsigned s);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 25; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= s) r = t;
        end
        if (s > r * r + r) r++;
        return r;
    endfunction

    function automatic logic [23:0] scale_coord(longint p, longint lo, longint hi,
                                                longint unsigned diag);
        longint          n;
        longint unsigned mag;
        longint unsigned q;
        n = (2 * p - (lo + hi)) * longint'(target);
        mag = (n < 0) ? longint'(-n) : n;
        q = (mag + diag) / (2 * diag);
        if (n < 0) return (q > 64'd8388608) ? 24'h800000 : 24'(-longint'(q));
        return (q > 64'd8388607) ? 24'h7fffff : 24'(q);
    endfunction

    task automatic predict_point(t_point p);
        t_scaled         r;
        longint unsigned dx, dy, dz, diag;
        if (pcount == 0 && !ovf) begin
            mn_x = p.x; mx_x = p.x; mn_y = p.y; mx_y = p.y; mn_z = p.z; mx_z = p.z;
        end else begin
            if (p.x < mn_x) mn_x = p.x;
            if (p.y < mn_y) mn_y = p.y;
            if (p.z < mn_z) mn_z = p.z;
            if (p.x > mx_x) mx_x = p.x;
            if (p.y > mx_y) mx_y = p.y;
            if (p.z > mx_z) mx_z = p.z;
        end
        if (pcount < csp_pkg::POINT_DEPTH) begin
            xs[pcount] = p.x; ys[pcount] = p.y; zs[pcount] = p.z;
            pcount++;
        end else ovf = 1'b1;
        if (!p.last) return;
        r = '{x: '0, y: '0, z: '0, status: csp_pkg::ST_OK, last: 1'b1};
        dx = longint'(mx_x) - longint'(mn_x);
        dy = longint'(mx_y) - longint'(mn_y);
        dz = longint'(mx_z) - longint'(mn_z);
        if (ovf) r.status = csp_pkg::ST_OVERFLOW;
        else if (pcount < 3) r.status = csp_pkg::ST_FEW;
        else if (dx * dx + dy * dy + dz * dz == 0) r.status = csp_pkg::ST_ZERO;
        if (r.status != csp_pkg::ST_OK) expected_points = {expected_points, r};
        else begin
            diag = isqrt_round(dx * dx + dy * dy + dz * dz);
            for (int i = 0; i < pcount; i++) begin
                r.x = scale_coord(xs[i], mn_x, mx_x, diag);
                r.y = scale_coord(ys[i], mn_y, mx_y, diag);
                r.z = scale_coord(zs[i], mn_z, mx_z, diag);
                r.last = (i == pcount - 1);
                expected_points = {expected_points, r};
            end
        end
        pcount = 0;
        ovf = 1'b0;
    endtask

    task automatic report(string what, logic [23:0] got, logic [23:0] want);
        error_count++;
        if (error_count <= 30)
            $display("error at cycle %0d result %0d: %s got %h want %h",
                     cycle_count, results_seen, what, got, want);
    endtask

    // driver
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predict_point(pending_points.pop_front());
                points_sent <= points_sent + 1;
            end
            if (i_s_tvalid && !(o_s_tready)) begin
                // hold the current transaction
            end else if (pending_points.size() > 0 && !hold_sender && gap_left == 0) begin
                t_point nx;
                nx = pending_points[0];
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {nx.z, nx.y, nx.x};
                i_s_tlast <= nx.last;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                end else burst_left--;
            end else begin
                i_s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // receiver stall pattern and monitor
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_tready <= (cycle_count % 7 < 3);
            endcase
            if (o_m_tvalid && i_m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_points.size() == 0) begin
                    report("unexpected result x", o_m_tdata[23:0], '0);
                end else begin
                    t_scaled e;
                    e = expected_points.pop_front();
                    if (o_m_tdata[23:0] !== e.x) report("out_x", o_m_tdata[23:0], e.x);
                    if (o_m_tdata[47:24] !== e.y) report("out_y", o_m_tdata[47:24], e.y);
                    if (o_m_tdata[71:48] !== e.z) report("out_z", o_m_tdata[71:48], e.z);
                    if (o_m_tuser !== e.status)
                        report("status", 24'(o_m_tuser), 24'(e.status));
                    if (o_m_tlast !== e.last)
                        report("end_of_run", 24'(o_m_tlast), 24'(e.last));
                    if (e.last) sets_done <= sets_done + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("timeout with %0d results outstanding", expected_points.size());
            $display("center_and_scale_point_set: mismatch");
            $finish;
        end
    end

    function automatic logic signed [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
            default: return ($urandom_range(0, 1)) ? 24'sh7fffff : 24'sh800000;
        endcase
    endfunction

    task automatic add_point(logic signed [23:0] x, y, z, logic last);
        t_point p;
        p = '{x: x, y: y, z: z, last: last};
        pending_points = {pending_points, p};
    endtask

    task automatic add_set(int n, int mode);
        for (int i = 0; i < n; i++)
            add_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == n - 1);
    endtask

    task automatic wait_idle();
        while (pending_points.size() != 0 || i_s_tvalid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_target(logic [22:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        target = v;
    endtask

    logic [22:0] targets[5] = '{23'd1, 23'h7fffff, 23'd25600, 23'd1000, 23'd300000};

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, few points, zero box, overflow
        add_point(24'sh7fffff, 24'sh800000, 24'sh7fffff, 1'b0);
        add_point(24'sh800000, 24'sh7fffff, 24'sh800000, 1'b0);
        add_point(24'sh000000, 24'sh555555, 24'shaaaaaa, 1'b1);
        add_point(24'sd5, 24'sd5, 24'sd5, 1'b1);
        add_point(24'sd5, 24'sd5, 24'sd5, 1'b0);
        add_point(24'sd9, 24'sd9, 24'sd9, 1'b1);
        add_point(24'sd7, -24'sd7, 24'sd0, 1'b0);
        add_point(24'sd7, -24'sd7, 24'sd0, 1'b0);
        add_point(24'sd7, -24'sd7, 24'sd0, 1'b1);
        add_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
        add_point(24'sd1, 24'sd0, 24'sd0, 1'b0);
        add_point(24'sd2, 24'sd0, 24'sd0, 1'b1);
        wait_idle();
        add_set(65, 1);
        wait_idle();
        foreach (targets[t]) begin
            set_target(targets[t]);
            for (int s = 0; s < 3; s++)
                add_set($urandom_range(3, 6), $urandom_range(0, 5) == 0 ? 2 :
                        $urandom_range(0, 1));
            add_set($urandom_range(1, 2), 1);
            if (t == 2) begin
                while (pending_points.size() > 8) @(posedge i_clk);
                hold_sender = 1'b1;
                while (expected_points.size() != 0 || i_s_tvalid) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_idle();
        end
        repeat (200) @(posedge i_clk);
        $display("covered %0d points in %0d sets, %0d results, %0d target settings",
                 points_sent, sets_done, results_seen, $size(targets));
        if (error_count == 0 && expected_points.size() == 0)
            $display("center_and_scale_point_set: match");
        else
            $display("center_and_scale_point_set: mismatch");
        $finish;
    end
endmodule

// ===== center_and_scale_point_set.f =====
+incdir+hw/rtl
hw/rtl/csp_pkg.sv
hw/rtl/csp_root_div.sv
hw/rtl/center_and_scale_point_set.sv
hw/rtl/csp_checker.sv
tb/tb_top.sv
